// File: rtl/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg: shared types and helpers of the pressure compensation block
// Payload structs, register indexes and word-level arithmetic helpers.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int unsigned DivW     = 32;
  localparam int unsigned CfgW     = 64;
  localparam int unsigned CfgIdxW  = 2;

  typedef enum logic [1:0] {
    RegCalOffsets   = 2'd0,
    RegCalScales    = 2'd1,
    RegCalCurvature = 2'd2,
    RegOversampling = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [15:0] raw_temperature;
    logic [23:0] raw_pressure;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] temperature_tenths;
    logic signed [31:0] pressure_pa;
    logic               error;
  } out_item_t;

  localparam logic [31:0] B6Offset  = 32'd4000;
  localparam logic [31:0] X3Bias    = 32'd32768;
  localparam logic [31:0] B7Scale   = 32'd50000;
  localparam logic [31:0] B7Half    = 32'h8000_0000;
  localparam logic [31:0] PolyA     = 32'd3038;
  localparam logic [31:0] PolyB     = 32'd7357;
  localparam logic [31:0] PolyC     = 32'd3791;

  // arithmetic right shift of a 32-bit word
  function automatic logic [31:0] asr(input logic [31:0] v, input int unsigned s);
    return $unsigned($signed(v) >>> s);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] w);
    return {{16{w[15]}}, w};
  endfunction

  function automatic logic [31:0] mag(input logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

endpackage

// File: rtl/bpc_div.sv
// ----------------------------------------------------------------------------
// bpc_div: pipelined unsigned divider
// One quotient bit per stage, restoring form; a side word travels along.
// ----------------------------------------------------------------------------
module bpc_div #(
  parameter int unsigned SideW = 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [bpc_pkg::DivW-1:0] num_i,
  input  logic [bpc_pkg::DivW-1:0] den_i,
  input  logic [SideW-1:0]         side_i,
  output logic                     valid_o,
  output logic [bpc_pkg::DivW-1:0] quo_o,
  output logic [SideW-1:0]         side_o
);

  localparam int unsigned W = bpc_pkg::DivW;

  logic [W-1:0]     rem_q  [W];
  logic [W-1:0]     num_q  [W];
  logic [W-1:0]     den_q  [W];
  logic [SideW-1:0] side_q [W];
  logic             vld_q  [W];

  for (genvar s = 0; s < W; s++) begin : g_stage
    logic [W-1:0]     r_in, n_in, d_in;
    logic [SideW-1:0] sd_in;
    logic             v_in;
    logic [W:0]       trial;

    if (s == 0) begin : g_first
      assign r_in  = '0;
      assign n_in  = num_i;
      assign d_in  = den_i;
      assign sd_in = side_i;
      assign v_in  = valid_i;
    end else begin : g_next
      assign r_in  = rem_q[s-1];
      assign n_in  = num_q[s-1];
      assign d_in  = den_q[s-1];
      assign sd_in = side_q[s-1];
      assign v_in  = vld_q[s-1];
    end

    assign trial = {r_in, n_in[W-1]} - {1'b0, d_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        // keep the remainder when the trial subtract goes negative
        rem_q[s]  <= trial[W] ? {r_in[W-2:0], n_in[W-1]} : trial[W-1:0];
        num_q[s]  <= {n_in[W-2:0], ~trial[W]};
        den_q[s]  <= d_in;
        side_q[s] <= sd_in;
      end
    end
  end

  assign valid_o = vld_q[W-1];
  assign quo_o   = num_q[W-1];
  assign side_o  = side_q[W-1];

endmodule

// File: rtl/barometric_pressure_compensation_top.sv
// ----------------------------------------------------------------------------
// barometric_pressure_compensation_top: temperature and pressure compensation
// Turns raw sensor words into 0.1 degree Celsius and pascals.
// ----------------------------------------------------------------------------
// The block takes one item per cycle while it is not stalled and returns
// one result per item, in order, through two 32-stage pipelined dividers
// plus 14 arithmetic stages. The whole pipeline advances together; it holds
// while a result sits in the output register and the output side stalls.
// The user must write calibration and oversampling through the plain write
// port while no item is in flight; the block does not enforce this. A zero
// divisor in either division sets error and forces both values to zero.
module barometric_pressure_compensation_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  bpc_pkg::in_item_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output bpc_pkg::out_item_t          out_data_o,
  input  logic                        cfg_we_i,
  input  logic [bpc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [bpc_pkg::CfgW-1:0]    cfg_data_i
);

  // ---------------------------------------------------------------- config
  logic [47:0] cal_off_q, cal_scl_q;
  logic [63:0] cal_crv_q;
  logic [1:0]  oss_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_off_q <= '0;
      cal_scl_q <= '0;
      cal_crv_q <= '0;
      oss_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (bpc_pkg::reg_idx_e'(cfg_index_i))
        bpc_pkg::RegCalOffsets:   cal_off_q <= cfg_data_i[47:0];
        bpc_pkg::RegCalScales:    cal_scl_q <= cfg_data_i[47:0];
        bpc_pkg::RegCalCurvature: cal_crv_q <= cfg_data_i;
        bpc_pkg::RegOversampling: oss_q     <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = bpc_pkg::sx16(cal_off_q[47:32]);
  assign ac2 = bpc_pkg::sx16(cal_off_q[31:16]);
  assign ac3 = bpc_pkg::sx16(cal_off_q[15:0]);
  assign ac4 = {16'd0, cal_scl_q[47:32]};
  assign ac5 = {16'd0, cal_scl_q[31:16]};
  assign ac6 = {16'd0, cal_scl_q[15:0]};
  assign b1  = bpc_pkg::sx16(cal_crv_q[63:48]);
  assign b2  = bpc_pkg::sx16(cal_crv_q[47:32]);
  assign mc  = bpc_pkg::sx16(cal_crv_q[31:16]);
  assign md  = bpc_pkg::sx16(cal_crv_q[15:0]);

  // ------------------------------------------------------- flow control
  // Advance every stage together unless the finished item is held.
  logic adv;
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  // ----------------------------------------- stage A: temperature product
  logic        va_q;
  logic [31:0] pa_q, upa_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) va_q <= 1'b0;
    else if (adv) va_q <= in_valid_i;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pa_q  <= ({16'd0, in_data_i.raw_temperature} - ac6) * ac5;
      upa_q <= {8'd0, in_data_i.raw_pressure} >> (4'd8 - {2'd0, oss_q});
    end
  end

  // ------------------------------------- stage B: set up signed division
  typedef struct packed {
    logic [31:0] x1;
    logic [31:0] up;
    logic        err;
    logic        neg;
  } d1_side_t;

  logic        vb_q;
  logic [31:0] nb_q, db_q;
  d1_side_t    sb_q;
  logic [31:0] x1b, denb, numb;
  assign x1b  = bpc_pkg::asr(pa_q, 15);
  assign denb = x1b + md;
  assign numb = mc << 11;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vb_q <= 1'b0;
    else if (adv) vb_q <= va_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      nb_q     <= bpc_pkg::mag(numb);
      db_q     <= bpc_pkg::mag(denb);
      sb_q.x1  <= x1b;
      sb_q.up  <= upa_q;
      sb_q.err <= (denb == 32'd0);
      sb_q.neg <= numb[31] ^ denb[31];
    end
  end

  logic        v1;
  logic [31:0] q1;
  d1_side_t    s1;
  bpc_div #(.SideW($bits(d1_side_t))) u_div_t (
    .clk_i, .rst_ni, .en_i(adv),
    .valid_i(vb_q), .num_i(nb_q), .den_i(db_q), .side_i(sb_q),
    .valid_o(v1), .quo_o(q1), .side_o(s1)
  );

  // ------------------------------------------------- stage C: b5 and b6
  logic        vc_q, errc_q;
  logic [31:0] b5c_q, b6c_q, upc_q;
  logic [31:0] x2c, b5c;
  assign x2c = s1.neg ? (32'd0 - q1) : q1;
  assign b5c = s1.x1 + x2c;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vc_q <= 1'b0;
    else if (adv) vc_q <= v1;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      b5c_q  <= b5c;
      b6c_q  <= b5c - bpc_pkg::B6Offset;
      upc_q  <= s1.up;
      errc_q <= s1.err;
    end
  end

  // ------------------------------------------------ stage D: b6 products
  logic        vd_q, errd_q;
  logic [31:0] b5d_q, upd_q, sqd_q, a2d_q, a3d_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vd_q <= 1'b0;
    else if (adv) vd_q <= vc_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sqd_q  <= b6c_q * b6c_q;
      a2d_q  <= ac2 * b6c_q;
      a3d_q  <= ac3 * b6c_q;
      b5d_q  <= b5c_q;
      upd_q  <= upc_q;
      errd_q <= errc_q;
    end
  end

  // ---------------------------------------------------- stage E: shifts
  logic        ve_q, erre_q;
  logic [31:0] b5e_q, upe_q, sqe_q, x2e_q, x1e_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ve_q <= 1'b0;
    else if (adv) ve_q <= vd_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sqe_q  <= bpc_pkg::asr(sqd_q, 12);
      x2e_q  <= bpc_pkg::asr(a2d_q, 11);
      x1e_q  <= bpc_pkg::asr(a3d_q, 13);
      b5e_q  <= b5d_q;
      upe_q  <= upd_q;
      erre_q <= errd_q;
    end
  end

  // ---------------------------------------------- stage F: curvature terms
  logic        vf_q, errf_q;
  logic [31:0] b5f_q, upf_q, m1f_q, m2f_q, x2f_q, x1f_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vf_q <= 1'b0;
    else if (adv) vf_q <= ve_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      m1f_q  <= b2 * sqe_q;
      m2f_q  <= b1 * sqe_q;
      x2f_q  <= x2e_q;
      x1f_q  <= x1e_q;
      b5f_q  <= b5e_q;
      upf_q  <= upe_q;
      errf_q <= erre_q;
    end
  end

  // ------------------------------------------------- stage G: b3 and x3
  logic        vg_q, errg_q;
  logic [31:0] b5g_q, upg_q, b3g_q, tg_q;
  logic [31:0] x3g, x3bg;
  assign x3g  = bpc_pkg::asr(m1f_q, 11) + x2f_q;
  assign x3bg = bpc_pkg::asr(bpc_pkg::asr(m2f_q, 16) + x1f_q + 32'd2, 2);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vg_q <= 1'b0;
    else if (adv) vg_q <= vf_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      b3g_q  <= bpc_pkg::asr((((ac1 << 2) + x3g) << oss_q) + 32'd2, 2);
      tg_q   <= x3bg + bpc_pkg::X3Bias;
      b5g_q  <= b5f_q;
      upg_q  <= upf_q;
      errg_q <= errf_q;
    end
  end

  // -------------------------------------------- stage H: b4 product, up-b3
  logic        vh_q, errh_q;
  logic [31:0] b5h_q, b4h_q, dh_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vh_q <= 1'b0;
    else if (adv) vh_q <= vg_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      b4h_q  <= ac4 * tg_q;
      dh_q   <= upg_q - b3g_q;
      b5h_q  <= b5g_q;
      errh_q <= errg_q;
    end
  end

  // ----------------------------------------------------- stage I: b4, b7
  logic        vi_q, erri_q;
  logic [31:0] b5i_q, b4i_q, b7i_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vi_q <= 1'b0;
    else if (adv) vi_q <= vh_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      b4i_q  <= b4h_q >> 15;
      b7i_q  <= dh_q * (bpc_pkg::B7Scale >> oss_q);
      b5i_q  <= b5h_q;
      erri_q <= errh_q;
    end
  end

  // ------------------------------------- stage J: set up pressure division
  typedef struct packed {
    logic [31:0] b5;
    logic        err;
    logic        post;
  } d2_side_t;

  logic        vj_q;
  logic [31:0] nj_q, dj_q;
  d2_side_t    sj_q;
  logic        small_b7;
  assign small_b7 = (b7i_q < bpc_pkg::B7Half);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vj_q <= 1'b0;
    else if (adv) vj_q <= vi_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      // double before the division while it cannot overflow, after otherwise
      nj_q      <= small_b7 ? (b7i_q << 1) : b7i_q;
      dj_q      <= b4i_q;
      sj_q.b5   <= b5i_q;
      sj_q.err  <= erri_q || (b4i_q == 32'd0);
      sj_q.post <= !small_b7;
    end
  end

  logic        v2;
  logic [31:0] q2;
  d2_side_t    s2;
  bpc_div #(.SideW($bits(d2_side_t))) u_div_p (
    .clk_i, .rst_ni, .en_i(adv),
    .valid_i(vj_q), .num_i(nj_q), .den_i(dj_q), .side_i(sj_q),
    .valid_o(v2), .quo_o(q2), .side_o(s2)
  );

  // --------------------------------------------------- stage K: raw p
  logic        vk_q, errk_q;
  logic [31:0] b5k_q, pk_q, qk_q;
  logic [31:0] pk;
  assign pk = s2.post ? (q2 << 1) : q2;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vk_q <= 1'b0;
    else if (adv) vk_q <= v2;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pk_q   <= pk;
      qk_q   <= bpc_pkg::asr(pk, 8);
      b5k_q  <= s2.b5;
      errk_q <= s2.err;
    end
  end

  // ------------------------------------------ stage L: correction squares
  logic        vl_q, errl_q;
  logic [31:0] b5l_q, pl_q, sql_q, ml_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vl_q <= 1'b0;
    else if (adv) vl_q <= vk_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sql_q  <= qk_q * qk_q;
      ml_q   <= 32'd0 - (bpc_pkg::PolyB * pk_q);
      pl_q   <= pk_q;
      b5l_q  <= b5k_q;
      errl_q <= errk_q;
    end
  end

  // -------------------------------------------- stage M: scaled square
  logic        vm_q, errm_q;
  logic [31:0] b5m_q, pm_q, x1m_q, x2m_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vm_q <= 1'b0;
    else if (adv) vm_q <= vl_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      x1m_q  <= sql_q * bpc_pkg::PolyA;
      x2m_q  <= bpc_pkg::asr(ml_q, 16);
      pm_q   <= pl_q;
      b5m_q  <= b5l_q;
      errm_q <= errl_q;
    end
  end

  // -------------------------------------------------- stage N: output
  logic [31:0] pn, tn;
  assign pn = pm_q + bpc_pkg::asr(bpc_pkg::asr(x1m_q, 16) + x2m_q + bpc_pkg::PolyC, 4);
  assign tn = bpc_pkg::asr(b5m_q + 32'd8, 4);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (adv) out_valid_o <= vm_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      // drop the values of an item whose division had a zero divisor
      out_data_o.temperature_tenths <= errm_q ? 16'sd0 : $signed(tn[15:0]);
      out_data_o.pressure_pa        <= errm_q ? 32'sd0 : $signed(pn);
      out_data_o.error              <= errm_q;
    end
  end

endmodule

// File: rtl/bpc_checker.sv
// ----------------------------------------------------------------------------
// bpc_checker: port-level checks of the compensation block
// Watches the top level's ports and reports violations.
// ----------------------------------------------------------------------------
module bpc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input bpc_pkg::out_item_t out_data_o
);

  a_stall_follows_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall does not track a held result");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.error) |->
      (out_data_o.temperature_tenths == 16'sd0 && out_data_o.pressure_pa == 32'sd0))
    else $error("error result carries nonzero values");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result shown during reset");

endmodule

bind barometric_pressure_compensation_top bpc_checker u_bpc_checker (
  .clk_i, .rst_ni, .in_stall_o, .out_valid_o, .out_stall_i, .out_data_o
);

// File: dv/tb_barometric_pressure_compensation_top.sv
// ----------------------------------------------------------------------------
// tb_barometric_pressure_compensation_top: self-checking bench of the block
// Drives directed and random raw sensor items under several calibrations,
// predicts each compensated result and compares the results in order.
// ----------------------------------------------------------------------------
module tb_barometric_pressure_compensation_top;
  import bpc_pkg::*;

  localparam int unsigned DrainCycles = 100;    // beyond the pipeline depth
  localparam int unsigned CycleLimit  = 300000;
  localparam int unsigned ItemsPerSet = 150;

  // one row of the directed table: a register write or an item
  typedef struct {
    bit          is_write;
    reg_idx_e    idx;
    logic [63:0] value;
    in_item_t    item;
    bit          typed;       // expected result given in the row itself
    out_item_t   result;
  } row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  logic      cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgW-1:0]    cfg_data;

  // bench copy of the calibration registers
  logic [47:0] cal_off;
  logic [47:0] cal_scl;
  logic [63:0] cal_crv;
  logic [1:0]  oss;

  out_item_t   pending_results[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  barometric_pressure_compensation_top u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Hard stop: no correct run gets anywhere near this.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("barometric_pressure_compensation_top: mismatch");
      $finish;
    end
  end

  function automatic logic [31:0] sra(input logic [31:0] v, input int unsigned s);
    return $signed(v) >>> s;
  endfunction

  function automatic logic [31:0] sext16(input logic [15:0] w);
    return {{16{w[15]}}, w};
  endfunction

  // Integer compensation, 32-bit wrap everywhere; zero divisor -> error item.
  function automatic out_item_t compensate(input in_item_t it);
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] ut, up, x1, x2, x3, den, b5, b6, b3, b4, b7, p, sq, q, t;
    longint      qs;
    out_item_t   r;
    r       = '0;
    r.error = 1'b1;
    ac1 = sext16(cal_off[47:32]);
    ac2 = sext16(cal_off[31:16]);
    ac3 = sext16(cal_off[15:0]);
    ac4 = {16'd0, cal_scl[47:32]};
    ac5 = {16'd0, cal_scl[31:16]};
    ac6 = {16'd0, cal_scl[15:0]};
    b1  = sext16(cal_crv[63:48]);
    b2  = sext16(cal_crv[47:32]);
    mc  = sext16(cal_crv[31:16]);
    md  = sext16(cal_crv[15:0]);
    ut  = {16'd0, it.raw_temperature};
    up  = {8'd0, it.raw_pressure} >> (4'd8 - oss);

    // temperature
    x1  = sra((ut - ac6) * ac5, 15);
    den = x1 + md;
    if (den == 32'd0) return r;
    qs  = longint'($signed(mc << 11)) / longint'($signed(den));
    x2  = qs[31:0];
    b5  = x1 + x2;

    // pressure
    b6 = b5 - B6Offset;
    sq = sra(b6 * b6, 12);
    x1 = sra(b2 * sq, 11);
    x2 = sra(ac2 * b6, 11);
    x3 = x1 + x2;
    b3 = sra(((ac1 * 32'd4 + x3) << oss) + 32'd2, 2);
    x1 = sra(ac3 * b6, 13);
    x2 = sra(b1 * sq, 16);
    x3 = sra(x1 + x2 + 32'd2, 2);
    b4 = (ac4 * (x3 + X3Bias)) >> 15;
    if (b4 == 32'd0) return r;

    b7 = (up - b3) * (B7Scale >> oss);
    if (b7 < B7Half) p = (b7 << 1) / b4;
    else             p = (b7 / b4) << 1;
    q  = sra(p, 8);
    x1 = q * q;
    x1 = sra(x1 * PolyA, 16);
    x2 = sra(32'd0 - PolyB * p, 16);
    p  = p + sra(x1 + x2 + PolyC, 4);

    t = sra(b5 + 32'd8, 4);
    r.temperature_tenths = t[15:0];
    r.pressure_pa        = p;
    r.error              = 1'b0;
    return r;
  endfunction

  task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
    $display("%0t %s: got %h, want %h", $time, field, got, want);
    mismatches++;
  endtask

  // Receiver: stall at random, change only at the falling edge.
  always @(negedge clk) begin
    out_stall = rst_n && ($urandom_range(99) < recv_stall_pct);
  end

  // Compare every accepted result against the oldest pending one.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report("unexpected item", {16'd0, out_data.temperature_tenths}, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.temperature_tenths !== want.temperature_tenths)
          report("temperature_tenths", {16'd0, out_data.temperature_tenths},
                 {16'd0, want.temperature_tenths});
        if (out_data.pressure_pa !== want.pressure_pa)
          report("pressure_pa", out_data.pressure_pa, want.pressure_pa);
        if (out_data.error !== want.error)
          report("error", {31'd0, out_data.error}, {31'd0, want.error});
      end
    end
  end

  // Present one item, hold it until accepted, record what it must produce.
  // Called just after a falling edge; leaves valid high for the next item.
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t given);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_data  = it;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(typed ? given : compensate(it));
    @(negedge clk);
  endtask

  // Drain the pipeline, then write one register.
  task automatic write_reg(input reg_idx_e idx, input logic [63:0] value);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      RegCalOffsets:   cal_off = value[47:0];
      RegCalScales:    cal_scl = value[47:0];
      RegCalCurvature: cal_crv = value;
      RegOversampling: oss     = value[1:0];
      default: ;
    endcase
  endtask

  function automatic in_item_t rand_item();
    in_item_t it;
    it.raw_temperature = 16'($urandom_range(16'hffff));
    it.raw_pressure    = 24'($urandom_range(24'hff_ffff));
    return it;
  endfunction

  // Mostly plausible calibration around typical factory words; now and then
  // fully random words to hit wrap and zero-divisor corners.
  task automatic random_calibration();
    if ($urandom_range(3) == 0) begin
      write_reg(RegCalOffsets, {$urandom, $urandom});
      write_reg(RegCalScales, {$urandom, $urandom});
      write_reg(RegCalCurvature, {$urandom, $urandom});
    end else begin
      write_reg(RegCalOffsets, 64'({16'(408 + $urandom_range(200) - 100),
                                    16'(-72 + $urandom_range(40) - 20),
                                    16'(-14383 + $urandom_range(2000) - 1000)}));
      write_reg(RegCalScales, 64'({16'(32741 - $urandom_range(2000)),
                                   16'(32757 - $urandom_range(2000)),
                                   16'(23153 + $urandom_range(2000) - 1000)}));
      write_reg(RegCalCurvature, {16'(6190 + $urandom_range(400) - 200),
                                  16'($urandom_range(8)),
                                  16'(-8711 + $urandom_range(400) - 200),
                                  16'(2868 + $urandom_range(400) - 200)});
    end
    write_reg(RegOversampling, 64'($urandom_range(3)));
  endtask

  localparam out_item_t DivZero = '{temperature_tenths: '0, pressure_pa: '0, error: 1'b1};

  function automatic row_t wr(input reg_idx_e idx, input logic [63:0] value);
    return '{is_write: 1'b1, idx: idx, value: value, item: '0, typed: 1'b0, result: '0};
  endfunction

  function automatic row_t it_row(input logic [15:0] ut, input logic [23:0] rp,
                                  input bit typed, input out_item_t res);
    return '{is_write: 1'b0, idx: RegCalOffsets, value: '0,
             item: '{raw_temperature: ut, raw_pressure: rp}, typed: typed, result: res};
  endfunction

  // Directed table: reset calibration, zero divisors, typical words, extremes.
  row_t directed[$];

  initial begin
    logic [63:0] cal_typ_off, cal_typ_scl, cal_typ_crv;
    cal_typ_off = {16'd0, 16'(408), 16'(-72), 16'(-14383)};
    cal_typ_scl = {16'd0, 16'(32741), 16'(32757), 16'(23153)};
    cal_typ_crv = {16'(6190), 16'(4), 16'(-8711), 16'(2868)};

    // After reset every word is zero: the temperature divisor is zero.
    directed.push_back(it_row(16'h0000, 24'h00_0000, 1, DivZero));
    directed.push_back(it_row(16'hffff, 24'hff_ffff, 1, DivZero));
    // Pressure divisor zero: ac4 = 0.
    directed.push_back(wr(RegCalOffsets, cal_typ_off));
    directed.push_back(wr(RegCalScales, {32'd0, cal_typ_scl[31:0]}));
    directed.push_back(wr(RegCalCurvature, cal_typ_crv));
    directed.push_back(it_row(16'd27898, 24'(23843 << 8), 1, DivZero));
    // Typical calibration, oversampling 0 and then 3.
    directed.push_back(wr(RegCalScales, cal_typ_scl));
    directed.push_back(it_row(16'd27898, 24'(23843 << 8), 0, '0));
    directed.push_back(it_row(16'h0000, 24'h00_0000, 0, '0));
    directed.push_back(it_row(16'hffff, 24'hff_ffff, 0, '0));
    directed.push_back(wr(RegOversampling, 64'd3));
    directed.push_back(it_row(16'd27898, 24'h5d_2300, 0, '0));
    directed.push_back(it_row(16'hffff, 24'h00_0000, 0, '0));
    directed.push_back(it_row(16'h0000, 24'hff_ffff, 0, '0));
    // All-ones and sign-bit extremes of the calibration words.
    directed.push_back(wr(RegCalOffsets, 64'hffff_ffff_ffff));
    directed.push_back(wr(RegCalScales, 64'hffff_ffff_ffff));
    directed.push_back(wr(RegCalCurvature, 64'h8000_8000_8000_7fff));
    directed.push_back(it_row(16'h8000, 24'h80_0000, 0, '0));
    directed.push_back(it_row(16'hffff, 24'hff_ffff, 0, '0));
    // Temperature divisor zero with ac5 = 0 and md = 0.
    directed.push_back(wr(RegCalScales, 64'hffff_0000_ffff));
    directed.push_back(wr(RegCalCurvature, 64'h7fff_7fff_7fff_0000));
    directed.push_back(it_row(16'h1234, 24'h65_4321, 1, DivZero));
  end

  initial begin
    int unsigned mode;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    cal_off        = '0;
    cal_scl        = '0;
    cal_crv        = '0;
    oss            = '0;
    send_idle_pct  = 15;
    recv_stall_pct = 68;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Walk the directed table.
    foreach (directed[i]) begin
      if (directed[i].is_write) write_reg(directed[i].idx, directed[i].value);
      else send_item(directed[i].item, directed[i].typed, directed[i].result);
    end

    // Random part: three idling modes, three calibrations each.
    for (mode = 0; mode < 3; mode++) begin
      send_idle_pct  = (mode == 0) ? 15 : (mode == 1) ? 68 : 0;
      recv_stall_pct = (mode == 0) ? 68 : (mode == 1) ? 15 : 0;
      repeat (3) begin
        random_calibration();
        repeat (ItemsPerSet) send_item(rand_item(), 0, '0);
      end
    end
    in_valid = 1'b0;

    // Drain, then give any stray result time to show up.
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("barometric_pressure_compensation_top: match");
    end else begin
      $display("barometric_pressure_compensation_top: mismatch");
    end
    $finish;
  end

endmodule
